// File: hw/rtl/dtq_pkg.sv
// ----------------------------------------------------------------------------
// Delimiter tokenizer package
// Shared constants, types and a helper function for the tokenizer blocks.
// ----------------------------------------------------------------------------
package dtq_pkg;

    // Sizing
    localparam int DELIM_SLOTS = 4;
    localparam int COUNT_WIDTH = 16;
    localparam int CH_W        = 8;
    localparam int OUT_W       = 16;
    localparam int CMP_W       = (COUNT_WIDTH > OUT_W) ? COUNT_WIDTH : OUT_W;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_W      = 5;
    localparam int REG_IDX_W   = 3;
    localparam int USED_W      = $clog2(DELIM_SLOTS + 1) + 1;

    // Characters
    localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CH_W-1:0] CH_QUOTE = 8'h22;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_DELIM_0     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_DELIM_LAST  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_DELIM_CNT   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_QUOTES_OFF  = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_TOKEN_LIMIT = 3'd6;

    // Result kinds on the output stream
    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_END  = 2'd1,
        KIND_DONE = 2'd2
    } t_kind;

    // Work queued from front to back
    typedef enum logic [1:0] {
        OP_BYTE,
        OP_END,
        OP_DONE,
        OP_END_DONE
    } t_op;

    typedef struct packed {
        t_op                 op;
        logic [CH_W-1:0]     data;
        logic [OUT_W-1:0]    index;
        logic [OUT_W-1:0]    total;
    } t_entry;

    // Live configuration
    typedef struct packed {
        logic [DELIM_SLOTS-1:0][CH_W-1:0] delim;
        logic [2:0]                       delim_count;
        logic                             quotes_off;
        logic [OUT_W-1:0]                 token_limit;
    } t_cfg;

    // Delimiter slot reset values: tab, LF, CR, space, then zero
    function automatic logic [CH_W-1:0] delim_reset(input int slot);
        logic [CH_W-1:0] v;
        unique case (slot)
            0:       v = 8'd9;
            1:       v = 8'd10;
            2:       v = 8'd13;
            3:       v = 8'd32;
            default: v = 8'd0;
        endcase
        return v;
    endfunction

endpackage

// File: hw/rtl/dtq_cfg.sv
// ----------------------------------------------------------------------------
// Tokenizer configuration registers
// APB-style register file holding delimiters, quote switch and token limit.
// ----------------------------------------------------------------------------
module dtq_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [dtq_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output dtq_pkg::t_cfg                o_cfg
);

    dtq_pkg::t_cfg                     r_cfg;
    logic [dtq_pkg::REG_IDX_W-1:0]     reg_idx;
    logic                              wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[dtq_pkg::ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign o_cfg   = r_cfg;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < dtq_pkg::DELIM_SLOTS; i++) begin
                r_cfg.delim[i] <= dtq_pkg::delim_reset(i);
            end
            r_cfg.delim_count <= 3'd4;
            r_cfg.quotes_off  <= 1'b0;
            r_cfg.token_limit <= '0;
        end else if (wr_en) begin
            for (int i = 0; i < dtq_pkg::DELIM_SLOTS; i++) begin
                if (i < 4 && reg_idx == 3'(i)) begin
                    r_cfg.delim[i] <= pwdata[7:0];
                end
            end
            if (reg_idx == dtq_pkg::REG_DELIM_CNT) begin
                r_cfg.delim_count <= pwdata[2:0];
            end
            if (reg_idx == dtq_pkg::REG_QUOTES_OFF) begin
                r_cfg.quotes_off <= pwdata[0];
            end
            if (reg_idx == dtq_pkg::REG_TOKEN_LIMIT) begin
                r_cfg.token_limit <= pwdata[15:0];
            end
        end
    end

    // Read mux
    always_comb begin
        prdata = '0;
        for (int i = 0; i < dtq_pkg::DELIM_SLOTS; i++) begin
            if (i < 4 && reg_idx == 3'(i)) begin
                prdata = 32'(r_cfg.delim[i]);
            end
        end
        if (reg_idx == dtq_pkg::REG_DELIM_CNT) begin
            prdata = 32'(r_cfg.delim_count);
        end
        if (reg_idx == dtq_pkg::REG_QUOTES_OFF) begin
            prdata = 32'(r_cfg.quotes_off);
        end
        if (reg_idx == dtq_pkg::REG_TOKEN_LIMIT) begin
            prdata = 32'(r_cfg.token_limit);
        end
    end

endmodule

// File: hw/rtl/dtq_front.sv
// ----------------------------------------------------------------------------
// Tokenizer front end
// Accepts characters, tracks scan mode and token count, queues result work.
// ----------------------------------------------------------------------------
module dtq_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dtq_pkg::t_cfg                 i_cfg,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [dtq_pkg::CH_W-1:0]      i_s_axis_tdata,   // [7:0] ch
    input  logic                          i_full,
    output logic                          o_push,
    output dtq_pkg::t_entry               o_entry
);

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_PLAIN,
        MODE_QUOTED,
        MODE_SWALLOW
    } t_mode;

    t_mode                             r_mode, n_mode;
    logic [dtq_pkg::COUNT_WIDTH-1:0]   r_count, n_count;
    logic [dtq_pkg::COUNT_WIDTH-1:0]   count_inc;
    logic [dtq_pkg::USED_W-1:0]        used;
    logic                              accept;
    logic                              is_delim;
    logic                              is_close;
    logic                              limit_hit;
    logic [dtq_pkg::CH_W-1:0]          ch;

    assign ch              = i_s_axis_tdata;
    assign o_s_axis_tready = !i_full;
    assign accept          = i_s_axis_tvalid && !i_full;

    // Classify the character against the active delimiter slots
    always_comb begin
        if (dtq_pkg::USED_W'(i_cfg.delim_count) > dtq_pkg::USED_W'(dtq_pkg::DELIM_SLOTS)) begin
            used = dtq_pkg::USED_W'(dtq_pkg::DELIM_SLOTS);
        end else begin
            used = dtq_pkg::USED_W'(i_cfg.delim_count);
        end
        is_delim = 1'b0;
        for (int i = 0; i < dtq_pkg::DELIM_SLOTS; i++) begin
            if (dtq_pkg::USED_W'(i) < used && i_cfg.delim[i] == ch) begin
                is_delim = 1'b1;
            end
        end
    end

    // Saturating count and limit test
    assign count_inc = (r_count == '1) ? r_count : r_count + 1'b1;
    assign limit_hit = (i_cfg.token_limit != '0) &&
                       (dtq_pkg::CMP_W'(count_inc) >= dtq_pkg::CMP_W'(i_cfg.token_limit));
    assign is_close  = (r_mode == MODE_PLAIN) ? is_delim : (ch == dtq_pkg::CH_QUOTE);

    // Next state and queued work
    always_comb begin
        n_mode        = r_mode;
        n_count       = r_count;
        o_push        = 1'b0;
        o_entry.op    = dtq_pkg::OP_BYTE;
        o_entry.data  = ch;
        o_entry.index = dtq_pkg::OUT_W'(r_count);
        o_entry.total = '0;
        if (accept) begin
            unique case (r_mode)
                MODE_SWALLOW: begin
                    if (ch == dtq_pkg::CH_NUL) begin
                        n_mode  = MODE_IDLE;
                        n_count = '0;
                    end
                end
                MODE_IDLE: begin
                    priority if (ch == dtq_pkg::CH_NUL) begin
                        o_push        = 1'b1;
                        o_entry.op    = dtq_pkg::OP_DONE;
                        o_entry.total = dtq_pkg::OUT_W'(r_count);
                        n_count       = '0;
                    end else if (is_delim) begin
                        n_mode = MODE_IDLE;
                    end else if (ch == dtq_pkg::CH_QUOTE && !i_cfg.quotes_off) begin
                        n_mode = MODE_QUOTED;
                    end else begin
                        o_push = 1'b1;
                        n_mode = MODE_PLAIN;
                    end
                end
                MODE_PLAIN, MODE_QUOTED: begin
                    priority if (ch == dtq_pkg::CH_NUL) begin
                        o_push        = 1'b1;
                        o_entry.op    = dtq_pkg::OP_END_DONE;
                        o_entry.total = dtq_pkg::OUT_W'(count_inc);
                        n_mode        = MODE_IDLE;
                        n_count       = '0;
                    end else if (is_close) begin
                        o_push        = 1'b1;
                        o_entry.total = dtq_pkg::OUT_W'(count_inc);
                        n_count       = count_inc;
                        if (limit_hit) begin
                            o_entry.op = dtq_pkg::OP_END_DONE;
                            n_mode     = MODE_SWALLOW;
                        end else begin
                            o_entry.op = dtq_pkg::OP_END;
                            n_mode     = MODE_IDLE;
                        end
                    end else begin
                        o_push = 1'b1;
                    end
                end
                default: begin
                    n_mode = r_mode;
                end
            endcase
        end
    end

    // Hold scan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_count <= '0;
        end else begin
            r_mode  <= n_mode;
            r_count <= n_count;
        end
    end

    // Swallowed input never produces results
    a_swallow_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_SWALLOW) |-> !o_push)
        else $error("push while swallowing");

    // A NUL always brings the scanner back to idle with a cleared count
    a_nul_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && ch == dtq_pkg::CH_NUL) |=> (r_mode == MODE_IDLE && r_count == '0))
        else $error("NUL did not reset the scanner");

    // No work is queued without an accepted character
    a_push_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> accept)
        else $error("push without accepted input");

endmodule

// File: hw/rtl/dtq_queue.sv
// ----------------------------------------------------------------------------
// Tokenizer work queue
// Short register queue between the front end and the result stage.
// ----------------------------------------------------------------------------
module dtq_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  dtq_pkg::t_entry   i_entry,
    output logic              o_full,
    input  logic              i_pop,
    output dtq_pkg::t_entry   o_head,
    output logic              o_empty
);

    dtq_pkg::t_entry                 r_mem [dtq_pkg::QUEUE_DEPTH];
    logic [dtq_pkg::QPTR_W-1:0]      r_wr_ptr, r_rd_ptr;
    logic [dtq_pkg::QCNT_W-1:0]      r_fill;

    assign o_full  = (r_fill == dtq_pkg::QCNT_W'(dtq_pkg::QUEUE_DEPTH));
    assign o_empty = (r_fill == '0);
    assign o_head  = r_mem[r_rd_ptr];

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_fill <= r_fill + 1'b1;
                2'b01:   r_fill <= r_fill - 1'b1;
                default: r_fill <= r_fill;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("pop from empty queue");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= dtq_pkg::QCNT_W'(dtq_pkg::QUEUE_DEPTH))
        else $error("queue fill out of range");

endmodule

// File: hw/rtl/dtq_back.sv
// ----------------------------------------------------------------------------
// Tokenizer result stage
// Expands queued work into output transfers through an output register.
// ----------------------------------------------------------------------------
module dtq_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  dtq_pkg::t_entry                 i_head,
    input  logic                            i_empty,
    output logic                            o_pop,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [39:0]                     o_m_axis_tdata,  // data_byte, token_index, token_total
    output logic [1:0]                      o_m_axis_tuser,  // kind
    output logic                            o_m_axis_tlast
);

    logic                          r_valid;
    logic                          r_phase, n_phase;
    dtq_pkg::t_kind                r_kind, n_kind;
    logic [dtq_pkg::CH_W-1:0]      r_data, n_data;
    logic [dtq_pkg::OUT_W-1:0]     r_index, n_index;
    logic [dtq_pkg::OUT_W-1:0]     r_total, n_total;
    logic                          r_last, n_last;
    logic                          load;

    assign load            = !r_valid || i_m_axis_tready;
    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tdata  = {r_total, r_index, r_data};
    assign o_m_axis_tuser  = r_kind;
    assign o_m_axis_tlast  = r_last;

    // Pick the next transfer from the queue head
    always_comb begin
        o_pop   = 1'b0;
        n_phase = r_phase;
        n_kind  = dtq_pkg::KIND_BYTE;
        n_data  = '0;
        n_index = '0;
        n_total = '0;
        n_last  = 1'b1;
        if (load && !i_empty) begin
            unique case (i_head.op)
                dtq_pkg::OP_BYTE: begin
                    o_pop   = 1'b1;
                    n_data  = i_head.data;
                    n_index = i_head.index;
                end
                dtq_pkg::OP_END: begin
                    o_pop   = 1'b1;
                    n_kind  = dtq_pkg::KIND_END;
                    n_index = i_head.index;
                end
                dtq_pkg::OP_DONE: begin
                    o_pop   = 1'b1;
                    n_kind  = dtq_pkg::KIND_DONE;
                    n_total = i_head.total;
                end
                dtq_pkg::OP_END_DONE: begin
                    if (!r_phase) begin
                        n_phase = 1'b1;
                        n_kind  = dtq_pkg::KIND_END;
                        n_index = i_head.index;
                        n_last  = 1'b0;
                    end else begin
                        o_pop   = 1'b1;
                        n_phase = 1'b0;
                        n_kind  = dtq_pkg::KIND_DONE;
                        n_total = i_head.total;
                    end
                end
                default: begin
                    o_pop = 1'b0;
                end
            endcase
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else if (load) begin
            r_valid <= !i_empty;
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind  <= n_kind;
            r_data  <= n_data;
            r_index <= n_index;
            r_total <= n_total;
            r_last  <= n_last;
        end
    end

    // Second half of a split entry always has its entry still queued
    a_phase_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |-> (!i_empty && i_head.op == dtq_pkg::OP_END_DONE))
        else $error("split entry lost from queue head");

    // The first half of a split entry is an end marker that is not last
    a_phase_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |-> (r_valid && r_kind == dtq_pkg::KIND_END && !r_last))
        else $error("split entry first half malformed");

    // Pop only when the output register takes the final transfer of an entry
    a_pop_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (load && !i_empty))
        else $error("pop without output load");

endmodule

// File: hw/rtl/delimiter_tokenizer_with_quotes_top.sv
// ----------------------------------------------------------------------------
// Delimiter tokenizer with quoted strings, top level
// Splits a NUL-terminated character stream into tokens with quoted strings.
//
//   Channel   Dir  Handshake           Payload
//   s_axis    in   tvalid/tready       tdata[7:0] ch
//   m_axis    out  tvalid/tready       tdata {token_total, token_index, data_byte},
//                                      tuser kind, tlast last
//   apb       in   psel/penable/pready paddr[4:2] register index, pwdata/prdata
//
// One character is accepted per cycle while the four-entry work queue has room.
// Results leave one per cycle while results are queued and m_axis tready is high;
// an end marker followed by done is sent as two transfers from one queued entry.
// Each character's work is registered in the work queue, then in the output register.
// Reset is synchronous, active low; no clearing pass is needed.
// Output stalls fill the queue and then deassert s_axis tready.
// ----------------------------------------------------------------------------
module delimiter_tokenizer_with_quotes_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [7:0]                  i_s_axis_tdata,   // [7:0] ch
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    output logic [39:0]                 o_m_axis_tdata,   // [7:0] data_byte, [23:8] token_index, [39:24] token_total
    output logic [1:0]                  o_m_axis_tuser,   // [1:0] kind
    output logic                        o_m_axis_tlast,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dtq_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    dtq_pkg::t_cfg    cfg;
    dtq_pkg::t_entry  push_entry;
    dtq_pkg::t_entry  head;
    logic             push;
    logic             pop;
    logic             full;
    logic             empty;

    dtq_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    dtq_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_full          (full),
        .o_push          (push),
        .o_entry         (push_entry)
    );

    dtq_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (full),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (empty)
    );

    dtq_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (head),
        .i_empty         (empty),
        .o_pop           (pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

endmodule
